/* sv/assert_macros.svh */
// Assertion macros used by the escaper top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check under reset.
`define JSE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// Implication check: antecedent implies consequent in the same cycle.
`define JSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`endif

/* sv/jse_pkg.sv */
// Types, constants and helper functions for the JSON string escaper.
// No dependencies.
package jse_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned UnitW = 16;
  localparam int unsigned CharW = 7;

  localparam logic [CpW-1:0] MaxCode  = 21'h10FFFF;
  localparam logic [CpW-1:0] SuppBase = 21'h010000;
  localparam logic [CpW-1:0] SurLo    = 21'h00D800;
  localparam logic [CpW-1:0] SurHi    = 21'h00DFFF;

  localparam logic [CpW-1:0] MIN_CODE [4] = '{21'h0, 21'h80, 21'h800, 21'h10000};

  localparam logic [CharW-1:0] ChBslash = 7'h5C;
  localparam logic [CharW-1:0] ChU      = 7'h75;
  localparam logic [CharW-1:0] ChNul    = 7'h00;

  // Decoded request handed to the emitter
  typedef struct packed {
    logic             is_err;
    logic             str_last;
    logic             two_units;
    logic [UnitW-1:0] u0;
    logic [UnitW-1:0] u1;
  } rec_t;

  // Second character of a two-character escape, zero if none
  function automatic logic [CharW-1:0] short_esc(input logic [UnitW-1:0] u);
    logic [CharW-1:0] r;
    case (u)
      16'h0022: r = 7'h22;
      16'h005C: r = 7'h5C;
      16'h0008: r = 7'h62;
      16'h000C: r = 7'h66;
      16'h000A: r = 7'h6E;
      16'h000D: r = 7'h72;
      16'h0009: r = 7'h74;
      default:  r = 7'h00;
    endcase
    return r;
  endfunction

  // Lowercase hex digit
  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] r;
    if (nib < 4'd10) r = 7'h30 + {3'b000, nib};
    else             r = 7'h57 + {3'b000, nib};
    return r;
  endfunction

endpackage

/* sv/jse_decode.sv */
// UTF-8 decoder: state registers and per-byte decode into UTF-16 units.
// Depends on jse_pkg.
module jse_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    in_byte_i,
  input  logic          string_last_i,
  output logic          rec_valid_o,
  output jse_pkg::rec_t rec_o
);
  import jse_pkg::*;

  logic [CpW-1:0] acc_q, acc_d;
  logic [1:0]     pend_q, pend_d;
  logic [1:0]     seql_q, seql_d;
  logic           skip_q, skip_d;

  logic           err, done, ok_out;
  logic [CpW-1:0] cp, acc_shift, v;
  logic [7:0]     b;

  assign b         = in_byte_i;
  assign acc_shift = {acc_q[CpW-7:0], b[5:0]};
  assign v         = cp - SuppBase;

  // Next state and decode result
  always_comb begin
    acc_d   = acc_q;
    pend_d  = pend_q;
    seql_d  = seql_q;
    skip_d  = skip_q;
    err     = 1'b0;
    done    = 1'b0;
    cp      = '0;
    ok_out  = 1'b0;
    if (!skip_q) begin
      if (pend_q == 2'd0) begin
        if (!b[7]) begin
          cp     = {13'd0, b};
          seql_d = 2'd0;
          done   = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          acc_d  = {16'd0, b[4:0]};
          pend_d = 2'd1;
          seql_d = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          acc_d  = {17'd0, b[3:0]};
          pend_d = 2'd2;
          seql_d = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          acc_d  = {18'd0, b[2:0]};
          pend_d = 2'd3;
          seql_d = 2'd3;
        end else begin
          err = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        err = 1'b1;
      end else begin
        acc_d  = acc_shift;
        pend_d = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          cp   = acc_shift;
          done = 1'b1;
        end
      end

      // Overlong, out of range and surrogate checks on completion; a string end mid-sequence is an error
      if (done) begin
        if (cp < MIN_CODE[seql_d] || cp > MaxCode || (cp >= SurLo && cp <= SurHi))
          err = 1'b1;
        else
          ok_out = 1'b1;
      end else if (!err && string_last_i) begin
        err = 1'b1;
      end

      if (err) begin
        acc_d  = '0;
        pend_d = 2'd0;
        seql_d = 2'd0;
        skip_d = ~string_last_i;
      end
    end
    if (string_last_i) begin
      acc_d  = '0;
      pend_d = 2'd0;
      seql_d = 2'd0;
      skip_d = 1'b0;
    end
  end

  // Request toward the emitter
  always_comb begin
    rec_o.is_err    = err;
    rec_o.str_last  = string_last_i;
    rec_o.two_units = ok_out && (cp >= SuppBase);
    if (cp >= SuppBase) begin
      rec_o.u0 = {6'b110110, v[19:10]};
      rec_o.u1 = {6'b110111, v[9:0]};
    end else begin
      rec_o.u0 = cp[UnitW-1:0];
      rec_o.u1 = '0;
    end
  end
  assign rec_valid_o = err | ok_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= 2'd0;
      seql_q <= 2'd0;
      skip_q <= 1'b0;
    end else if (fire_i) begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
      seql_q <= seql_d;
      skip_q <= skip_d;
    end
  end

endmodule

/* sv/jse_emit.sv */
// Holding slot and character emitter: one escaped character per cycle while out_ready_i is high.
// Depends on jse_pkg.
module jse_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jse_pkg::rec_t rec_i,
  output logic          ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [6:0]    out_char_o,
  output logic          run_last_o,
  output logic          string_end_o,
  output logic          bad_utf8_o
);
  import jse_pkg::*;

  logic pslot_valid_q;
  rec_t pslot_q;
  logic em_valid_q;
  rec_t em_q;
  logic sel_q;
  logic [2:0] pos_q;

  logic [UnitW-1:0] unit;
  logic [CharW-1:0] esc, ch;
  logic             uesc, unit_end, rlast, em_done, em_free, slot_go;
  logic [2:0]       last_pos;

  // Character selection for the current unit and position
  assign unit = sel_q ? em_q.u1 : em_q.u0;
  assign esc  = short_esc(unit);
  assign uesc = (unit < 16'h0020) || (unit >= 16'h0080);

  always_comb begin
    if (esc != ChNul)   last_pos = 3'd1;
    else if (uesc)      last_pos = 3'd5;
    else                last_pos = 3'd0;
    ch = unit[CharW-1:0];
    if (esc != ChNul) begin
      ch = (pos_q == 3'd0) ? ChBslash : esc;
    end else if (uesc) begin
      case (pos_q)
        3'd0:    ch = ChBslash;
        3'd1:    ch = ChU;
        3'd2:    ch = hex_char(unit[15:12]);
        3'd3:    ch = hex_char(unit[11:8]);
        3'd4:    ch = hex_char(unit[7:4]);
        default: ch = hex_char(unit[3:0]);
      endcase
    end
    if (em_q.is_err) ch = ChNul;
  end

  assign unit_end = (pos_q == last_pos);
  assign rlast    = em_q.is_err || (unit_end && (sel_q || !em_q.two_units));

  assign out_valid_o  = em_valid_q;
  assign out_char_o   = ch;
  assign run_last_o   = rlast;
  assign string_end_o = rlast & em_q.str_last;
  assign bad_utf8_o   = em_q.is_err;

  assign em_done = em_valid_q & out_ready_i & rlast;
  assign em_free = ~em_valid_q | em_done;
  assign slot_go = pslot_valid_q & em_free;
  assign ready_o = ~pslot_valid_q | em_free;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pslot_valid_q <= 1'b0;
      em_valid_q    <= 1'b0;
      sel_q         <= 1'b0;
      pos_q         <= 3'd0;
    end else begin
      if (push_i)       pslot_valid_q <= 1'b1;
      else if (slot_go) pslot_valid_q <= 1'b0;
      if (em_free) begin
        em_valid_q <= pslot_valid_q;
        sel_q      <= 1'b0;
        pos_q      <= 3'd0;
      end else if (out_ready_i) begin
        if (unit_end) begin
          sel_q <= 1'b1;
          pos_q <= 3'd0;
        end else begin
          pos_q <= pos_q + 3'd1;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (push_i)  pslot_q <= rec_i;
    if (slot_go) em_q    <= pslot_q;
  end

endmodule

/* sv/json_string_escaper.sv */
// Top level of the JSON string escaper: UTF-8 bytes in, escaped ASCII out.
// Depends on jse_pkg, jse_decode, jse_emit and assert_macros.svh.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | in_byte_i, string_last_i
//  out     | out_valid_o/out_ready_i | out_char_o, run_last_o, string_end_o,
//          |                         | bad_utf8_o
//
// One byte is taken per cycle while in_ready_o is high; the emitter sends each
// result character in turn, up to 12 characters for a surrogate pair.
// Lead bytes produce nothing unless they end the string; skipped bytes produce nothing.
// Reset clears decoder state and both request slots; no clearing pass.
// A held output stalls the input only once the holding slot is also full.
`include "assert_macros.svh"
module json_string_escaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       string_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] out_char_o,
  output logic       run_last_o,
  output logic       string_end_o,
  output logic       bad_utf8_o
);
  import jse_pkg::*;

  logic fire, rec_valid;
  rec_t rec;

  assign fire = in_valid_i & in_ready_o;

  // Decode bytes into UTF-16 units
  jse_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .in_byte_i     (in_byte_i),
    .string_last_i (string_last_i),
    .rec_valid_o   (rec_valid),
    .rec_o         (rec)
  );

  // Serialize escaped characters
  jse_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (fire & rec_valid),
    .rec_i        (rec),
    .ready_o      (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o),
    .bad_utf8_o   (bad_utf8_o)
  );

  // Checks
  `JSE_ASSERT_IMP(a_err_form, clk_i, rst_ni, out_valid_o && bad_utf8_o, run_last_o && out_char_o == 7'd0)
  `JSE_ASSERT_IMP(a_end_last, clk_i, rst_ni, out_valid_o && string_end_o, run_last_o)
  `JSE_ASSERT(a_stall_cause, clk_i, rst_ni, in_ready_o || out_valid_o)

endmodule
